// ===== hdl/scs_pkg.sv =====
// Shared types and constants for the staggered channel enable sequencer.
`timescale 1ns / 1ps

package scs_pkg;

  localparam int unsigned CH_W       = 4;
  localparam int unsigned LEN_W      = 4;
  localparam int unsigned DELAY_W    = 16;
  localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd1000;

  typedef enum logic [1:0] {
    OP_ENABLE = 2'd0,
    OP_STOP   = 2'd1,
    OP_TICK   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OFF     = 2'd0,
    ST_ON      = 2'd1,
    ST_PENDING = 2'd2
  } chan_state_e;

  // Command broadcast to every slot cell of the wait queue.
  typedef struct packed {
    logic [CH_W-1:0]  ch;
    logic             rm_en;
    logic             pop;
    logic             ins;
    logic [LEN_W-1:0] len;
  } slot_cmd_t;

  // Control of the switch delay timer.
  typedef struct packed {
    logic start;
    logic tick;
  } tmr_ctrl_t;

endpackage

// ===== hdl/scs_slot_cell.sv =====
// One slot of the wait queue: holds a channel code and shifts toward the head.
`timescale 1ns / 1ps

module scs_slot_cell #(
  parameter int unsigned IDX      = 0,
  parameter int unsigned CHANNELS = 9
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  scs_pkg::slot_cmd_t       cmd_i,
  input  logic                     seen_i,
  input  logic [scs_pkg::CH_W-1:0] next1_i,
  input  logic [scs_pkg::CH_W-1:0] next2_i,
  output logic [scs_pkg::CH_W-1:0] slot_o,
  output logic                     match_o,
  output logic                     seen_o
);

  localparam logic [scs_pkg::CH_W-1:0] NoneCode = scs_pkg::CH_W'(CHANNELS);

  logic [scs_pkg::CH_W-1:0] slot_q, slot_d;
  logic                     rm;

  assign match_o = (slot_q != NoneCode) && (slot_q == cmd_i.ch);
  assign seen_o  = seen_i | match_o;
  // A removal at this slot or any slot closer to the head moves this slot up.
  assign rm      = cmd_i.rm_en & seen_o;
  assign slot_o  = slot_q;

  always_comb begin
    case ({rm, cmd_i.pop})
      2'b11:          slot_d = next2_i;
      2'b10, 2'b01:   slot_d = next1_i;
      default: begin
        if (cmd_i.ins && (cmd_i.len == scs_pkg::LEN_W'(IDX))) begin
          slot_d = cmd_i.ch;
        end else begin
          slot_d = slot_q;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= NoneCode;
    end else begin
      slot_q <= slot_d;
    end
  end

endmodule

// ===== hdl/scs_delay_timer.sv =====
// Switch delay register and one-shot countdown timer.
`timescale 1ns / 1ps

module scs_delay_timer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [scs_pkg::DELAY_W-1:0] cfg_data_i,
  input  scs_pkg::tmr_ctrl_t          ctrl_i,
  output logic                        active_o,
  output logic                        expire_o
);

  logic [scs_pkg::DELAY_W-1:0] ticks_q;
  logic [scs_pkg::DELAY_W-1:0] count_q, count_d;
  logic                        active_q, active_d;

  assign expire_o = ctrl_i.tick && active_q && (count_q == scs_pkg::DELAY_W'(1));
  assign active_o = active_q;

  always_comb begin
    count_d  = count_q;
    active_d = active_q;
    if (ctrl_i.start) begin
      // A zero delay behaves as one tick.
      count_d  = (ticks_q == '0) ? scs_pkg::DELAY_W'(1) : ticks_q;
      active_d = 1'b1;
    end else if (ctrl_i.tick && active_q) begin
      count_d = count_q - scs_pkg::DELAY_W'(1);
      if (expire_o) begin
        active_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q  <= scs_pkg::DELAY_RESET;
      count_q  <= '0;
      active_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        ticks_q <= cfg_data_i;
      end
      count_q  <= count_d;
      active_q <= active_d;
    end
  end

endmodule

// ===== hdl/staggered_channel_enable_sequencer.sv =====
// Top level of the staggered channel enable sequencer.
`timescale 1ns / 1ps

// Switches on load channels one at a time so that only one is pre-heating.
// Each input transaction (enable request, stop, or millisecond tick) is
// fully processed in the cycle it is accepted and yields exactly one result
// transaction carrying the updated status; a new transaction is accepted
// every cycle unless a result is still waiting with the output stalled.
// The wait queue is a row of slot cells that match and shift in parallel,
// so queue removal and advance complete in that single cycle. The delay
// register (reset 1000 ticks, 0 acts as 1) may be written whenever the
// block is idle.
module staggered_channel_enable_sequencer #(
  parameter int unsigned CHANNELS = 9
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [scs_pkg::DELAY_W-1:0]  cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   op_i,
  input  logic [scs_pkg::CH_W-1:0]     channel_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [2*CHANNELS-1:0]        status_vector_o,
  output logic [scs_pkg::CH_W-1:0]     preheat_channel_o,
  output logic [scs_pkg::LEN_W-1:0]    queue_length_o,
  output logic                         timer_running_o
);

  localparam logic [scs_pkg::CH_W-1:0]  NoneCode = scs_pkg::CH_W'(CHANNELS);
  localparam logic [scs_pkg::LEN_W-1:0] MaxLen   = scs_pkg::LEN_W'(CHANNELS);

  logic                         out_valid_q;
  logic [2*CHANNELS-1:0]        status_q, status_d;
  logic [scs_pkg::CH_W-1:0]     pre_q, pre_d;
  logic [scs_pkg::LEN_W-1:0]    len_q, len_d, len_rm;

  logic [scs_pkg::CH_W-1:0]     slot_w [CHANNELS+2];
  logic                         match_w [CHANNELS];
  logic                         seen_w [CHANNELS+1];

  scs_pkg::slot_cmd_t           cmd;
  scs_pkg::tmr_ctrl_t           tmr;
  logic                         timer_active, timer_expire;

  logic acc, ch_ok, is_en, is_stop, is_tick;
  logic en_live, en_now, en_queue, rm, adv, pop;
  logic [scs_pkg::CH_W-1:0] head;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign acc        = in_valid_i && !in_stall_o;
  assign ch_ok      = channel_i < NoneCode;
  assign is_en      = acc && (op_i == scs_pkg::OP_ENABLE) && ch_ok;
  assign is_stop    = acc && (op_i == scs_pkg::OP_STOP) && ch_ok;
  assign is_tick    = acc && (op_i == scs_pkg::OP_TICK);

  assign en_live  = is_en && (channel_i != pre_q);
  assign en_now   = en_live && (pre_q == NoneCode);
  assign en_queue = en_live && (pre_q != NoneCode) && !seen_w[CHANNELS] && (len_q < MaxLen);
  assign rm       = is_stop && seen_w[CHANNELS];
  assign len_rm   = len_q - scs_pkg::LEN_W'(rm);
  assign adv      = (is_stop && (pre_q == channel_i)) || timer_expire;
  assign pop      = adv && (len_rm != '0);
  // Queue head after a stop has removed its channel.
  assign head     = (rm && match_w[0]) ? slot_w[1] : slot_w[0];

  assign cmd.ch    = channel_i;
  assign cmd.rm_en = is_stop;
  assign cmd.pop   = pop;
  assign cmd.ins   = en_queue;
  assign cmd.len   = len_q;

  assign tmr.tick  = is_tick;
  assign tmr.start = (en_queue && (len_q == '0)) ||
                     (pop && (len_rm != scs_pkg::LEN_W'(1)));

  assign slot_w[CHANNELS]   = NoneCode;
  assign slot_w[CHANNELS+1] = NoneCode;
  assign seen_w[0]          = 1'b0;

  for (genvar gi = 0; gi < CHANNELS; gi++) begin : g_slot
    scs_slot_cell #(
      .IDX      (gi),
      .CHANNELS (CHANNELS)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .seen_i  (seen_w[gi]),
      .next1_i (slot_w[gi+1]),
      .next2_i (slot_w[gi+2]),
      .slot_o  (slot_w[gi]),
      .match_o (match_w[gi]),
      .seen_o  (seen_w[gi+1])
    );
  end

  scs_delay_timer u_timer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .ctrl_i     (tmr),
    .active_o   (timer_active),
    .expire_o   (timer_expire)
  );

  always_comb begin
    if (en_queue) begin
      len_d = len_q + scs_pkg::LEN_W'(1);
    end else begin
      len_d = len_rm - scs_pkg::LEN_W'(pop);
    end

    if (en_now) begin
      pre_d = channel_i;
    end else if (adv) begin
      pre_d = pop ? head : NoneCode;
    end else begin
      pre_d = pre_q;
    end
  end

  // Per-channel state lanes; the advance applies after a stop.
  always_comb begin
    status_d = status_q;
    for (int j = 0; j < CHANNELS; j++) begin
      if (is_stop && (channel_i == scs_pkg::CH_W'(j))) begin
        status_d[2*j +: 2] = scs_pkg::ST_OFF;
      end
      if (en_now && (channel_i == scs_pkg::CH_W'(j))) begin
        status_d[2*j +: 2] = scs_pkg::ST_ON;
      end
      if (en_queue && (channel_i == scs_pkg::CH_W'(j))) begin
        status_d[2*j +: 2] = scs_pkg::ST_PENDING;
      end
      if (pop && (head == scs_pkg::CH_W'(j))) begin
        status_d[2*j +: 2] = scs_pkg::ST_ON;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      status_q    <= '0;
      pre_q       <= NoneCode;
      len_q       <= '0;
    end else begin
      if (acc) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      status_q <= status_d;
      pre_q    <= pre_d;
      len_q    <= len_d;
    end
  end

  // State changes only when a transaction is accepted, so the result fields
  // read straight from the state registers.
  assign out_valid_o       = out_valid_q;
  assign status_vector_o   = status_q;
  assign preheat_channel_o = pre_q;
  assign queue_length_o    = len_q;
  assign timer_running_o   = timer_active;

`ifndef SYNTHESIS
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= MaxLen)
    else $error("queue length exceeds channel count");

  a_queue_has_pre: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (len_q != '0) |-> (pre_q != NoneCode))
    else $error("channels wait while none is pre-heating");

  a_queue_timer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (len_q != '0) |-> timer_active)
    else $error("channels wait without a running delay timer");

  a_pre_is_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pre_q < NoneCode) |-> (status_q[2*pre_q +: 2] == scs_pkg::ST_ON))
    else $error("pre-heating channel is not on");

  a_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !acc |=> ($stable(len_q) && $stable(pre_q) && $stable(status_q)))
    else $error("state changed without a transaction");
`endif

endmodule

// ===== dv/staggered_channel_enable_sequencer_test.sv =====
// Self-checking testbench for the staggered channel enable sequencer.
`timescale 1ns / 1ps

module staggered_channel_enable_sequencer_test;

  localparam int unsigned CHANNELS = 9;
  localparam logic [scs_pkg::CH_W-1:0] NONE_CODE = scs_pkg::CH_W'(CHANNELS);
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int unsigned PHASE_ITEMS = 125;

  typedef struct packed {
    logic [2*CHANNELS-1:0]     status;
    logic [scs_pkg::CH_W-1:0]  heating;
    logic [scs_pkg::LEN_W-1:0] qlen;
    logic                      timer;
  } status_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e                   kind;
    logic [1:0]                  op;
    logic [scs_pkg::CH_W-1:0]    ch;
    logic [scs_pkg::DELAY_W-1:0] cfg;
    logic                        typed;
    status_t                     res;
  } step_t;

  localparam status_t IDLE_RES = '{status: '0, heating: NONE_CODE, qlen: '0, timer: 1'b0};

  logic                        clk_i;
  logic                        rst_ni;
  logic                        cfg_we_i;
  logic [scs_pkg::DELAY_W-1:0] cfg_data_i;
  logic                        in_valid_i;
  logic                        in_stall_o;
  logic [1:0]                  op_i;
  logic [scs_pkg::CH_W-1:0]    channel_i;
  logic                        out_valid_o;
  logic                        out_stall_i;
  logic [2*CHANNELS-1:0]       status_vector_o;
  logic [scs_pkg::CH_W-1:0]    preheat_channel_o;
  logic [scs_pkg::LEN_W-1:0]   queue_length_o;
  logic                        timer_running_o;

  staggered_channel_enable_sequencer #(
    .CHANNELS(CHANNELS)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .op_i             (op_i),
    .channel_i        (channel_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_vector_o  (status_vector_o),
    .preheat_channel_o(preheat_channel_o),
    .queue_length_o   (queue_length_o),
    .timer_running_o  (timer_running_o)
  );

  // Mirror of the sequencer state.
  logic [scs_pkg::CH_W-1:0]    waiting[$];
  scs_pkg::chan_state_e        chan_st[CHANNELS];
  logic [scs_pkg::CH_W-1:0]    heating;
  logic [scs_pkg::DELAY_W-1:0] tmr_count;
  logic                        tmr_on;
  logic [scs_pkg::DELAY_W-1:0] delay_reg;

  status_t status_due_q[$];
  status_t head_res;
  int      errors;
  int      items_sent;
  int      results_checked;
  int      settings_used;
  int      deepest_queue;

  int      stall_mode;
  int      mode_left;
  int      run_left;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("%0t: timeout with %0d results outstanding", $time, status_due_q.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic void start_timer();
    tmr_count = (delay_reg == '0) ? scs_pkg::DELAY_W'(1) : delay_reg;
    tmr_on    = 1'b1;
  endfunction

  function automatic void advance_heating();
    if (waiting.size() == 0) begin
      heating = NONE_CODE;
    end else begin
      heating = waiting.pop_front();
      chan_st[heating] = scs_pkg::ST_ON;
      if (waiting.size() > 0) start_timer();
    end
  endfunction

  function automatic status_t predict_status(logic [1:0] op,
                                             logic [scs_pkg::CH_W-1:0] ch);
    status_t r;
    bit      queued;
    case (op)
      scs_pkg::OP_ENABLE: begin
        if (ch < CHANNELS && ch != heating) begin
          if (heating == NONE_CODE) begin
            heating = ch;
            chan_st[ch] = scs_pkg::ST_ON;
          end else begin
            queued = 1'b0;
            foreach (waiting[i]) if (waiting[i] == ch) queued = 1'b1;
            if (!queued && waiting.size() < CHANNELS) begin
              waiting.push_back(ch);
              chan_st[ch] = scs_pkg::ST_PENDING;
              if (waiting.size() == 1) start_timer();
            end
          end
        end
      end
      scs_pkg::OP_STOP: begin
        if (ch < CHANNELS) begin
          for (int i = 0; i < waiting.size(); i++) begin
            if (waiting[i] == ch) begin
              waiting.delete(i);
              break;
            end
          end
          chan_st[ch] = scs_pkg::ST_OFF;
          if (heating == ch) advance_heating();
        end
      end
      scs_pkg::OP_TICK: begin
        if (tmr_on) begin
          if (tmr_count > 0) tmr_count--;
          if (tmr_count == 0) begin
            tmr_on = 1'b0;
            advance_heating();
          end
        end
      end
      default: ;
    endcase
    for (int i = 0; i < CHANNELS; i++) r.status[2*i +: 2] = chan_st[i];
    r.heating = heating;
    r.qlen    = scs_pkg::LEN_W'(waiting.size());
    r.timer   = tmr_on;
    return r;
  endfunction

  // Presents one transaction and records its expected status once accepted.
  task automatic send_item(input logic [1:0] op, input logic [scs_pkg::CH_W-1:0] ch,
                           input logic typed, input status_t typed_res);
    status_t r;
    @(negedge clk_i);
    in_valid_i = 1'b1;
    op_i       = op;
    channel_i  = ch;
    do @(posedge clk_i); while (in_stall_o);
    r = predict_status(op, ch);
    if (typed) r = typed_res;
    status_due_q.push_back(r);
    items_sent++;
    if (waiting.size() > deepest_queue) deepest_queue = waiting.size();
  endtask

  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
    end
  endtask

  // The register is only written once the block has drained.
  task automatic write_delay(input logic [scs_pkg::DELAY_W-1:0] value);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (status_due_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_data_i = value;
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
    delay_reg  = value;
    settings_used++;
  endtask

  // The receiver alternates between no stall, scattered stalls and long stalls.
  always @(negedge clk_i) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left  = $urandom_range(16, 80);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      0: out_stall_i = 1'b0;
      1: out_stall_i = ($urandom_range(0, 9) < 3);
      default: begin
        if (run_left == 0) begin
          out_stall_i = ~out_stall_i;
          run_left    = $urandom_range(1, 12);
        end else begin
          run_left--;
        end
      end
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (status_due_q.size() == 0) begin
        $display("%0t: result transaction with nothing expected, status %h", $time,
                 status_vector_o);
        errors++;
      end else begin
        head_res = status_due_q.pop_front();
        results_checked++;
        if (status_vector_o !== head_res.status) begin
          $display("%0t: status_vector expected %h actual %h", $time, head_res.status,
                   status_vector_o);
          errors++;
        end
        if (preheat_channel_o !== head_res.heating) begin
          $display("%0t: preheat_channel expected %0d actual %0d", $time, head_res.heating,
                   preheat_channel_o);
          errors++;
        end
        if (queue_length_o !== head_res.qlen) begin
          $display("%0t: queue_length expected %0d actual %0d", $time, head_res.qlen,
                   queue_length_o);
          errors++;
        end
        if (timer_running_o !== head_res.timer) begin
          $display("%0t: timer_running expected %0d actual %0d", $time, head_res.timer,
                   timer_running_o);
          errors++;
        end
      end
    end
  end

  initial begin : stimulus
    step_t                       plan [27];
    logic [scs_pkg::DELAY_W-1:0] delays [6];
    int                          burst_left;
    int                          draw;
    logic [1:0]                  rop;
    logic [scs_pkg::CH_W-1:0]    rch;

    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    op_i        = scs_pkg::OP_TICK;
    channel_i   = '0;
    out_stall_i = 1'b0;
    stall_mode  = 0;
    mode_left   = 0;
    run_left    = 0;
    errors = 0; items_sent = 0; results_checked = 0; settings_used = 1; deepest_queue = 0;

    waiting.delete();
    foreach (chan_st[i]) chan_st[i] = scs_pkg::ST_OFF;
    heating   = NONE_CODE;
    tmr_count = '0;
    tmr_on    = 1'b0;
    delay_reg = scs_pkg::DELAY_RESET;

    // Rows that leave the block untouched carry their expected status inline.
    plan = '{
      '{ROW_ITEM, scs_pkg::OP_TICK,   4'd0,  16'd0,     1'b1, IDLE_RES},
      '{ROW_ITEM, scs_pkg::OP_ENABLE, 4'd9,  16'd0,     1'b1, IDLE_RES},
      '{ROW_ITEM, scs_pkg::OP_STOP,   4'd15, 16'd0,     1'b1, IDLE_RES},
      '{ROW_ITEM, OP_UNUSED,          4'd5,  16'd0,     1'b1, IDLE_RES},
      '{ROW_ITEM, scs_pkg::OP_STOP,   4'd4,  16'd0,     1'b1, IDLE_RES},
      '{ROW_CFG,  scs_pkg::OP_TICK,   4'd0,  16'd0,     1'b0, IDLE_RES},
      '{ROW_ITEM, scs_pkg::OP_ENABLE, 4'd0,  16'd0,     1'b0, IDLE_RES},
      '{ROW_ITEM, scs_pkg::OP_ENABLE, 4'd0,  16'd0,     1'b0, IDLE_RES},
      '{ROW_ITEM, scs_pkg::OP_ENABLE, 4'd8,  16'd0,     1'b0, IDLE_RES},
      '{ROW_ITEM, scs_pkg::OP_ENABLE, 4'd8,  16'd0,     1'b0, IDLE_RES},
      '{ROW_ITEM, scs_pkg::OP_TICK,   4'd0,  16'd0,     1'b0, IDLE_RES},
      '{ROW_ITEM, scs_pkg::OP_ENABLE, 4'd0,  16'd0,     1'b0, IDLE_RES},
      '{ROW_ITEM, scs_pkg::OP_STOP,   4'd8,  16'd0,     1'b0, IDLE_RES},
      '{ROW_ITEM, scs_pkg::OP_TICK,   4'd0,  16'd0,     1'b0, IDLE_RES},
      '{ROW_CFG,  scs_pkg::OP_TICK,   4'd0,  16'hFFFF,  1'b0, IDLE_RES},
      '{ROW_ITEM, scs_pkg::OP_ENABLE, 4'd3,  16'd0,     1'b0, IDLE_RES},
      '{ROW_ITEM, scs_pkg::OP_ENABLE, 4'd7,  16'd0,     1'b0, IDLE_RES},
      '{ROW_ITEM, scs_pkg::OP_ENABLE, 4'd1,  16'd0,     1'b0, IDLE_RES},
      '{ROW_ITEM, scs_pkg::OP_ENABLE, 4'd5,  16'd0,     1'b0, IDLE_RES},
      '{ROW_ITEM, scs_pkg::OP_ENABLE, 4'd8,  16'd0,     1'b0, IDLE_RES},
      '{ROW_ITEM, scs_pkg::OP_STOP,   4'd1,  16'd0,     1'b0, IDLE_RES},
      '{ROW_ITEM, scs_pkg::OP_STOP,   4'd8,  16'd0,     1'b0, IDLE_RES},
      '{ROW_ITEM, scs_pkg::OP_STOP,   4'd3,  16'd0,     1'b0, IDLE_RES},
      '{ROW_ITEM, scs_pkg::OP_ENABLE, 4'd15, 16'd0,     1'b0, IDLE_RES},
      '{ROW_CFG,  scs_pkg::OP_TICK,   4'd0,  16'd1,     1'b0, IDLE_RES},
      '{ROW_ITEM, scs_pkg::OP_STOP,   4'd7,  16'd0,     1'b0, IDLE_RES},
      '{ROW_ITEM, scs_pkg::OP_STOP,   4'd5,  16'd0,     1'b0, IDLE_RES}
    };

    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (plan[r]) begin
      if (plan[r].kind == ROW_CFG) begin
        write_delay(plan[r].cfg);
      end else begin
        send_item(plan[r].op, plan[r].ch, plan[r].typed, plan[r].res);
      end
    end

    delays[0] = 16'd1;
    delays[1] = 16'd2;
    delays[2] = 16'd3;
    delays[3] = scs_pkg::DELAY_W'($urandom_range(4, 12));
    delays[4] = 16'hFFFF;
    delays[5] = scs_pkg::DELAY_RESET;
    burst_left = 0;

    // Each phase starts from a drained block, so the sender also waits out
    // every outstanding result at least once.
    foreach (delays[p]) begin
      write_delay(delays[p]);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (burst_left == 0) begin
          idle_cycles($urandom_range(0, 6));
          burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        draw = $urandom_range(0, 99);
        if (draw < 40) rop = scs_pkg::OP_ENABLE;
        else if (draw < 62) rop = scs_pkg::OP_STOP;
        else if (draw < 95) rop = scs_pkg::OP_TICK;
        else rop = OP_UNUSED;
        if ($urandom_range(0, 19) == 0) rch = scs_pkg::CH_W'($urandom_range(9, 15));
        else rch = scs_pkg::CH_W'($urandom_range(0, CHANNELS - 1));
        send_item(rop, rch, 1'b0, IDLE_RES);
      end
    end

    idle_cycles(1);
    while (status_due_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    $display("Sent %0d transactions over %0d delay settings; %0d results checked.",
             items_sent, settings_used, results_checked);
    $display("Deepest wait queue reached %0d channels.", deepest_queue);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
